@@ sv/stq_pkg.sv @@
// Shared types and codes of the sorted timer queue.
// Used by stq_cell, stq_ctrl and sorted_timer_queue_core; depends on nothing.
package stq_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  // Input item
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  timer_id;
    logic [31:0] duration;
    logic [7:0]  priority_req;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic       status;
    logic       fired;
    logic [3:0] fired_id;
    logic [4:0] queued_count;
  } out_item_t;

  // One queue slot: timer id, absolute deadline and tie-break rank
  typedef struct packed {
    logic        v;
    logic [3:0]  id;
    logic [31:0] dl;
    logic [7:0]  rank;
  } ent_t;

  // Token that walks the chain one cell per cycle.
  // ins = 0: drop pass, flag marks that the target was found.
  // ins = 1: insert pass, flag marks that the carried entry was placed.
  typedef struct packed {
    logic        v;
    logic        ins;
    logic [3:0]  target;
    logic        flag;
    logic [31:0] mine;
    ent_t        carry;
  } tok_t;

endpackage

@@ sv/stq_cell.sv @@
// One slot of the sorted timer chain plus the token stage that follows it.
// Depends on stq_pkg (ent_t, tok_t).
module stq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      now_ticks,
  input  logic [31:0]      max_duration,
  input  stq_pkg::tok_t    tok_in,
  input  stq_pkg::ent_t    right_ent,
  output stq_pkg::ent_t    ent,
  output stq_pkg::tok_t    tok_out
);

  stq_pkg::ent_t ent_r, ent_nxt;
  stq_pkg::tok_t tok_r, tok_nxt;

  logic [31:0] theirs_raw;
  logic [31:0] theirs;
  logic        goes_before;

  // Remaining time of the stored timer, overdue counts as zero
  assign theirs_raw = ent_r.dl - now_ticks;
  assign theirs     = (theirs_raw > max_duration) ? 32'd0 : theirs_raw;

  // Stored timer stays ahead of the carried one
  assign goes_before = (theirs < tok_in.mine) ||
                       ((theirs == tok_in.mine) && (ent_r.rank <= tok_in.carry.rank));

  // Act on the token passing through this cell
  always_comb begin
    ent_nxt = ent_r;
    tok_nxt = tok_in;
    if (tok_in.v) begin
      if (!tok_in.ins) begin
        // drop: from the match on, pull each slot from the right
        if (tok_in.flag || (ent_r.v && (ent_r.id == tok_in.target))) begin
          ent_nxt      = right_ent;
          tok_nxt.flag = 1'b1;
        end
      end else begin
        // insert: place once, then shift the rest right by swapping
        if (tok_in.flag) begin
          ent_nxt       = tok_in.carry;
          tok_nxt.carry = ent_r;
        end else if (!(ent_r.v && goes_before)) begin
          ent_nxt       = tok_in.carry;
          tok_nxt.carry = ent_r;
          tok_nxt.flag  = 1'b1;
        end
      end
    end
  end

  // Hold slot and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.v <= 1'b0;
      tok_r.v <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign ent     = ent_r;
  assign tok_out = tok_r;

endmodule

@@ sv/stq_ctrl.sv @@
// Sequencer of the sorted timer queue: time base, limit register, queue
// length, token launch into the cell chain and the result register.
// Depends on stq_pkg.
module stq_ctrl #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  stq_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output stq_pkg::out_item_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data,
  input  stq_pkg::ent_t        head_ent,
  input  stq_pkg::tok_t        last_tok,
  output stq_pkg::tok_t        inj,
  output logic [31:0]          now_ticks,
  output logic [31:0]          max_duration
);

  localparam int LW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_DROP,
    S_INSERT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [31:0]        max_r, max_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  stq_pkg::in_item_t  req_r, req_nxt;
  stq_pkg::tok_t      inj_r, inj_nxt;
  logic               status_r, status_nxt;
  logic               fired_r, fired_nxt;
  logic [3:0]         fired_id_r, fired_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  stq_pkg::out_item_t out_r, out_nxt;

  logic        in_acc;
  logic        id_ok;
  logic        dur_bad;
  logic [31:0] head_raw;
  logic        head_due;

  assign in_acc  = in_valid && !in_stall;
  assign id_ok   = (32'(in_data.timer_id) < NUM_TIMERS);
  assign dur_bad = (in_data.duration == 32'd0) || (in_data.duration > max_r);

  // Head expires when its remaining time is zero or overdue
  assign head_raw = head_ent.dl - now_r;
  assign head_due = head_ent.v && ((head_raw == 32'd0) || (head_raw > max_r));

  // Sequence one item at a time and form the result
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    max_nxt       = max_r;
    len_nxt       = len_r;
    req_nxt       = req_r;
    inj_nxt       = '0;
    status_nxt    = status_r;
    fired_nxt     = fired_r;
    fired_id_nxt  = fired_id_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cfg_valid && cfg_ready) begin
      max_nxt = cfg_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_data;
          status_nxt   = 1'b0;
          fired_nxt    = 1'b0;
          fired_id_nxt = 4'd0;
          unique case (in_data.func)
            stq_pkg::FUNC_TICK: begin
              now_nxt   = now_r + 32'd1;
              state_nxt = S_HEAD;
            end
            stq_pkg::FUNC_START: begin
              if (dur_bad) begin
                status_nxt = 1'b1;
                state_nxt  = S_DONE;
              end else if (id_ok) begin
                inj_nxt.v      = 1'b1;
                inj_nxt.target = in_data.timer_id;
                state_nxt      = S_DROP;
              end else begin
                state_nxt = S_DONE;
              end
            end
            stq_pkg::FUNC_STOP: begin
              if (id_ok) begin
                inj_nxt.v      = 1'b1;
                inj_nxt.target = in_data.timer_id;
                state_nxt      = S_DROP;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_HEAD: begin
        if (head_due) begin
          fired_nxt      = 1'b1;
          fired_id_nxt   = head_ent.id;
          inj_nxt.v      = 1'b1;
          inj_nxt.target = head_ent.id;
          state_nxt      = S_DROP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DROP: begin
        // wait for the token to leave the last cell
        if (last_tok.v) begin
          if (last_tok.flag) begin
            len_nxt = len_r - LW'(1);
          end
          if (req_r.func == stq_pkg::FUNC_START) begin
            inj_nxt.v          = 1'b1;
            inj_nxt.ins        = 1'b1;
            inj_nxt.mine       = req_r.duration;
            inj_nxt.carry.v    = 1'b1;
            inj_nxt.carry.id   = req_r.timer_id;
            inj_nxt.carry.dl   = now_r + req_r.duration;
            inj_nxt.carry.rank = req_r.priority_req;
            state_nxt          = S_INSERT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_INSERT: begin
        if (last_tok.v) begin
          len_nxt   = len_r + LW'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // load the result once the output slot is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.status       = status_r;
          out_nxt.fired        = fired_r;
          out_nxt.fired_id     = fired_id_r;
          out_nxt.queued_count = 5'(len_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold sequencer state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= 32'd0;
      max_r       <= 32'd2147483647;
      len_r       <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      max_r       <= max_nxt;
      len_r       <= len_nxt;
      req_r       <= req_nxt;
      inj_r       <= inj_nxt;
      status_r    <= status_nxt;
      fired_r     <= fired_nxt;
      fired_id_r  <= fired_id_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  // Take a limit write only between items, and hold the input off while one is offered
  assign in_stall     = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready    = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign inj          = inj_r;
  assign now_ticks    = now_r;
  assign max_duration = max_r;

  // Queue never holds more timers than cells
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= NUM_TIMERS)
    else $error("queue length exceeds cell count");

  // A token leaves the chain only while a pass is under way
  a_tok_state: assert property (@(posedge clk) disable iff (!rst_n)
    last_tok.v |-> (state_r == S_DROP) || (state_r == S_INSERT))
    else $error("token left chain outside a pass");

  // An insert pass always finds a place
  a_ins_placed: assert property (@(posedge clk) disable iff (!rst_n)
    (last_tok.v && last_tok.ins) |-> last_tok.flag)
    else $error("insert pass left entry unplaced");

  // Each pass is launched with a single token
  a_inj_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    inj_r.v |=> !inj_r.v)
    else $error("token launched on two cycles in a row");

endmodule

@@ sv/sorted_timer_queue_core.sv @@
// Top level of the sorted timer queue: controller plus a chain of NUM_TIMERS cells.
// Depends on stq_pkg, stq_cell and stq_ctrl.
//
// Holds up to NUM_TIMERS one-shot timers in a chain of cells kept in queue order,
// head in the first cell. Items are handled one at a time. Start and stop walk a
// token down the chain one cell per clock to remove the timer and close the gap;
// a start then walks a second token that drops the new timer into place and
// shifts the rest. A tick that fires nothing, a rejected start, an unused code and
// an id out of range walk no token; a stop or a firing tick walks one, an accepted
// start two. in_stall is high while an item is in work; a finished result waits in
// the output register, and a result held there by out_stall keeps the next item
// from finishing. The max_duration register is written through cfg_valid/cfg_ready
// between items only: cfg_ready is low while an item is in work and a pending write
// holds the input off. It resets to 2147483647. No clearing pass follows reset.
module sorted_timer_queue_core #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stq_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stq_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  stq_pkg::ent_t ent_w [NUM_TIMERS];
  stq_pkg::tok_t tok_w [NUM_TIMERS];
  stq_pkg::tok_t inj;
  logic [31:0]   now_ticks;
  logic [31:0]   max_duration;

  // Sequence items and own the time base
  stq_ctrl #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .head_ent     (ent_w[0]),
    .last_tok     (tok_w[NUM_TIMERS-1]),
    .inj          (inj),
    .now_ticks    (now_ticks),
    .max_duration (max_duration)
  );

  // Build the chain: token flows right, entries pull from the right on a drop
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stq_pkg::tok_t tok_left;
    stq_pkg::ent_t ent_right;

    if (i == 0) begin : g_first
      assign tok_left = inj;
    end else begin : g_mid
      assign tok_left = tok_w[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_last
      assign ent_right = '0;
    end else begin : g_inner
      assign ent_right = ent_w[i+1];
    end

    stq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .now_ticks    (now_ticks),
      .max_duration (max_duration),
      .tok_in       (tok_left),
      .right_ent    (ent_right),
      .ent          (ent_w[i]),
      .tok_out      (tok_w[i])
    );
  end

endmodule
